// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: rtl/core/gfm_pkg.sv
// Package of the GF(2) polynomial multiplier: sizes, codes, port structs and
// the 32 by 32 carry-less product. No dependencies.
`default_nettype none

package gfm_pkg;

  // Operand length in 64-bit words, and derived sizes.
  localparam int OPERAND_WORDS = 80;
  localparam int PRODUCT_WORDS = 2 * OPERAND_WORDS;
  localparam int OP_ADDR_W     = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
  localparam int PROD_ADDR_W   = $clog2(PRODUCT_WORDS);
  localparam int INDEX_W       = 8;
  localparam int CMP_W         = 10;
  localparam int WORD_W        = 64;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  // Operand store read request from the sequencer.
  typedef struct packed {
    logic                 re;
    logic [OP_ADDR_W-1:0] a_addr;
    logic [OP_ADDR_W-1:0] b_addr;
  } op_rd_t;

  // Product store read request.
  typedef struct packed {
    logic                   re;
    logic [PROD_ADDR_W-1:0] addr;
  } prod_rd_t;

  // Product store write request.
  typedef struct packed {
    logic                   we;
    logic [PROD_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]      data;
  } prod_wr_t;

  // Carry-less product of two 32-bit words.
  function automatic logic [62:0] clmul32(input logic [31:0] x, input logic [31:0] y);
    logic [62:0] acc;
    acc = '0;
    for (int k = 0; k < 32; k++) begin
      if (y[k]) begin
        acc = acc ^ ({31'b0, x} << k);
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gfm_op_store.sv
// Operand store: two synchronous memories holding the words of both operands.
// Depends on gfm_pkg.
`default_nettype none

module gfm_op_store
  import gfm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [OP_ADDR_W-1:0] waddr_i,
  input  wire logic [WORD_W-1:0]    a_wdata_i,
  input  wire logic [WORD_W-1:0]    b_wdata_i,
  input  wire op_rd_t               rd_i,
  output logic      [WORD_W-1:0]    a_rdata_o,
  output logic      [WORD_W-1:0]    b_rdata_o
);

  logic [WORD_W-1:0] a_mem [OPERAND_WORDS];
  logic [WORD_W-1:0] b_mem [OPERAND_WORDS];
  logic [WORD_W-1:0] a_rdata_q;
  logic [WORD_W-1:0] b_rdata_q;

  // Both words of a pair are written together.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      a_mem[waddr_i] <= a_wdata_i;
      b_mem[waddr_i] <= b_wdata_i;
    end
  end

  // Registered reads, one address per memory.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      a_rdata_q <= a_mem[rd_i.a_addr];
      b_rdata_q <= b_mem[rd_i.b_addr];
    end
  end

  assign a_rdata_o = a_rdata_q;
  assign b_rdata_o = b_rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/gfm_prod_store.sv
// Product store: one synchronous memory of double-length product words.
// Depends on gfm_pkg.
`default_nettype none

module gfm_prod_store
  import gfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire prod_wr_t          wr_i,
  input  wire prod_rd_t          rd_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [PRODUCT_WORDS];
  logic [WORD_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/gfm_clmul_pipe.sv
// Two-stage 64 by 64 carry-less multiplier: four 32-bit partial products,
// then their combination into a low and a high word. Depends on gfm_pkg.
`default_nettype none

module gfm_clmul_pipe
  import gfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [WORD_W-1:0] a_i,
  input  wire logic [WORD_W-1:0] b_i,
  output logic      [WORD_W-1:0] lo_o,
  output logic      [WORD_W-1:0] hi_o
);

  logic [62:0]         ll_q;
  logic [62:0]         lh_q;
  logic [62:0]         hl_q;
  logic [62:0]         hh_q;
  logic [2*WORD_W-1:0] full;
  logic [WORD_W-1:0]   lo_q;
  logic [WORD_W-1:0]   hi_q;

  // First stage: the four half-word products.
  always_ff @(posedge clk_i) begin
    ll_q <= clmul32(a_i[31:0],  b_i[31:0]);
    lh_q <= clmul32(a_i[31:0],  b_i[63:32]);
    hl_q <= clmul32(a_i[63:32], b_i[31:0]);
    hh_q <= clmul32(a_i[63:32], b_i[63:32]);
  end

  // Second stage: align and merge the partial products.
  always_comb begin
    full = {65'b0, ll_q}
         ^ ({65'b0, lh_q} << 32)
         ^ ({65'b0, hl_q} << 32)
         ^ ({65'b0, hh_q} << 64);
  end

  always_ff @(posedge clk_i) begin
    lo_q <= full[WORD_W-1:0];
    hi_q <= full[2*WORD_W-1:WORD_W];
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

// File: rtl/core/gfm_seq.sv
// Compute sequencer: walks the operand word pairs row by row, feeds the
// multiplier and accumulates into the product store. Depends on gfm_pkg.
`default_nettype none

module gfm_seq
  import gfm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] prod_rdata_i,
  input  wire logic [WORD_W-1:0] lo_i,
  input  wire logic [WORD_W-1:0] hi_i,
  output logic                   busy_o,
  output logic                   done_o,
  output op_rd_t                 op_rd_o,
  output prod_rd_t               prod_rd_o,
  output prod_wr_t               prod_wr_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_TAIL  = 4'b1000
  } seq_state_e;

  localparam logic [OP_ADDR_W-1:0] LastWord = OP_ADDR_W'(OPERAND_WORDS - 1);

  seq_state_e             state_q, state_d;
  logic [OP_ADDR_W-1:0]   i_q, i_d;
  logic [OP_ADDR_W-1:0]   j_q, j_d;
  logic                   v1_q, v2_q, v3_q;
  logic                   f1_q, f2_q, f3_q;
  logic [PROD_ADDR_W-1:0] addr1_q, addr2_q, addr3_q;
  logic [WORD_W-1:0]      carry_q, carry_d;
  logic                   issue;
  logic [WORD_W-1:0]      old_word;
  logic [WORD_W-1:0]      carry_in;

  assign issue = (state_q == ST_ISSUE);

  // Row and column counters and state sequence.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (j_q == LastWord) begin
          j_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Wait until the last pair of the row has been written back.
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (i_q == LastWord) begin
          state_d = ST_IDLE;
          done_o  = 1'b1;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_ISSUE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  // Target address and first-column mark travel alongside the multiplier.
  always_ff @(posedge clk_i) begin
    addr1_q <= PROD_ADDR_W'(i_q) + PROD_ADDR_W'(j_q);
    f1_q    <= (j_q == '0);
    addr2_q <= addr1_q;
    f2_q    <= f1_q;
    addr3_q <= addr2_q;
    f3_q    <= f2_q;
    carry_q <= carry_d;
  end

  // Operand reads for the pair at (i, j).
  always_comb begin
    op_rd_o.re     = issue;
    op_rd_o.a_addr = i_q;
    op_rd_o.b_addr = j_q;
  end

  // Old product word is fetched in the cycle before its update.
  always_comb begin
    prod_rd_o.re   = v2_q;
    prod_rd_o.addr = addr2_q;
  end

  // The first row finds the store unwritten and starts from zero; the first
  // column of each row starts with no carry.
  assign old_word = (i_q == '0) ? '0 : prod_rdata_i;
  assign carry_in = f3_q ? '0 : carry_q;

  // Write back: accumulate one word per pair, then the row's final carry.
  always_comb begin
    carry_d        = carry_q;
    prod_wr_o.we   = 1'b0;
    prod_wr_o.addr = addr3_q;
    prod_wr_o.data = old_word ^ lo_i ^ carry_in;
    if (v3_q) begin
      prod_wr_o.we = 1'b1;
      carry_d      = hi_i;
    end else if (state_q == ST_TAIL) begin
      prod_wr_o.we   = 1'b1;
      prod_wr_o.addr = PROD_ADDR_W'(i_q) + PROD_ADDR_W'(OPERAND_WORDS);
      prod_wr_o.data = carry_q;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/gf2_polynomial_multiplier.sv
// Carry-less (GF(2)) polynomial multiplier with word-addressed operand and
// product stores. The input channel (in_valid_i / in_stall_o) carries one
// command per transfer: func 0 loads one 64-bit word of each operand at
// index, func 1 computes the full double-length product, func 2 reads one
// product word, func 3 does nothing. The output channel (out_valid_o /
// out_stall_i) returns exactly one result per command: read_data_o and
// status_o (0 ok, 1 index out of range, 2 product not yet computed).
// Load and read commands stream at one per cycle while the receiver keeps up;
// each result passes through a pending stage and then the output register.
// A compute command holds off further input for OPERAND_WORDS rows: the
// sequencer issues one word pair per cycle to the two-stage multiplier and
// the single product store write port, then drains the pipeline and writes
// the row's carry. While the receiver stalls, the output register holds and
// the pending stage fills, after which in_stall_o rises. Reset clears the
// handshake state and the product-valid mark; the stores keep no reset
// value and need no pass.
// Depends on gfm_pkg and the gfm_* submodules.
`default_nettype none

module gf2_polynomial_multiplier
  import gfm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [INDEX_W-1:0] index_i,
  input  wire logic [WORD_W-1:0]  a_word_i,
  input  wire logic [WORD_W-1:0]  b_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WORD_W-1:0]  read_data_o,
  output logic      [1:0]         status_o
);

  localparam logic [CMP_W-1:0] OpLimit   = CMP_W'(OPERAND_WORDS);
  localparam logic [CMP_W-1:0] ProdLimit = CMP_W'(PRODUCT_WORDS);

  func_e             func;
  logic [CMP_W-1:0]  index_ext;
  logic              accept;
  logic              op_in_range;
  logic              prod_in_range;
  status_e           status_new;
  logic              load_we;
  logic              start;

  logic              p_valid_q, p_valid_d;
  func_e             p_func_q;
  status_e           p_status_q;
  logic              o_load;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] read_data_q;
  status_e           status_q;
  logic              prod_valid_q, prod_valid_d;

  logic              seq_busy;
  logic              seq_done;
  op_rd_t            op_rd;
  prod_rd_t          seq_prod_rd;
  prod_rd_t          prod_rd;
  prod_wr_t          prod_wr;
  logic [WORD_W-1:0] a_rdata;
  logic [WORD_W-1:0] b_rdata;
  logic [WORD_W-1:0] prod_rdata;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;

  assign func      = func_e'(func_i);
  assign index_ext = CMP_W'(index_i);

  // Input transfer: blocked during a compute or when the pending stage is full and cannot pass its result on.
  assign o_load     = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = seq_busy || (p_valid_q && !o_load);
  assign accept     = in_valid_i && !in_stall_o;

  // Range checks and status of the command being taken.
  assign op_in_range   = (index_ext < OpLimit);
  assign prod_in_range = (index_ext < ProdLimit);

  always_comb begin
    status_new = STATUS_OK;
    case (func)
      FUNC_LOAD: begin
        if (!op_in_range) begin
          status_new = STATUS_RANGE;
        end
      end
      FUNC_READ: begin
        if (!prod_in_range) begin
          status_new = STATUS_RANGE;
        end else if (!prod_valid_q) begin
          status_new = STATUS_NOT_READY;
        end
      end
      default: begin
        status_new = STATUS_OK;
      end
    endcase
  end

  assign load_we = accept && (func == FUNC_LOAD) && op_in_range;
  assign start   = accept && (func == FUNC_COMPUTE);

  // Product-valid mark: cleared by an in-range load, set when a compute completes.
  always_comb begin
    prod_valid_d = prod_valid_q;
    if (load_we) begin
      prod_valid_d = 1'b0;
    end else if (seq_done) begin
      prod_valid_d = 1'b1;
    end
  end

  // Pending stage: waits for the product store read data.
  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (o_load) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_func_q   <= func;
      p_status_q <= status_new;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (o_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      status_q <= p_status_q;
      if ((p_func_q == FUNC_READ) && (p_status_q == STATUS_OK)) begin
        read_data_q <= prod_rdata;
      end else begin
        read_data_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      p_valid_q    <= p_valid_d;
      out_valid_q  <= out_valid_d;
      prod_valid_q <= prod_valid_d;
    end
  end

  // Product store read port: the sequencer owns it during a compute.
  always_comb begin
    if (seq_busy) begin
      prod_rd = seq_prod_rd;
    end else begin
      prod_rd.re   = accept && (func == FUNC_READ);
      prod_rd.addr = PROD_ADDR_W'(index_i);
    end
  end

  gfm_op_store u_op_store (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (OP_ADDR_W'(index_i)),
    .a_wdata_i (a_word_i),
    .b_wdata_i (b_word_i),
    .rd_i      (op_rd),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata)
  );

  gfm_clmul_pipe u_clmul_pipe (
    .clk_i (clk_i),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .lo_o  (lo),
    .hi_o  (hi)
  );

  gfm_prod_store u_prod_store (
    .clk_i   (clk_i),
    .wr_i    (prod_wr),
    .rd_i    (prod_rd),
    .rdata_o (prod_rdata)
  );

  gfm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .prod_rdata_i (prod_rdata),
    .lo_i         (lo),
    .hi_i         (hi),
    .busy_o       (seq_busy),
    .done_o       (seq_done),
    .op_rd_o      (op_rd),
    .prod_rd_o    (seq_prod_rd),
    .prod_wr_o    (prod_wr)
  );

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// File: rtl/core/gfm_checker.sv
// Port-level checker for the GF(2) polynomial multiplier, bound to the top
// level. Depends on gfm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module gfm_checker
  import gfm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        func_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [WORD_W-1:0] read_data_o,
  input wire logic [1:0]        status_o
);

  // A stalled result stays offered.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
               out_valid_o && out_stall_i |=> out_valid_o,
               "result dropped while stalled")

  // A stalled result keeps its payload.
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni,
               out_valid_o && out_stall_i |=> $stable(read_data_o) && $stable(status_o),
               "stalled payload changed")

  // A failed command never returns data.
  `ASSERT_NEVER(a_err_data, clk_i, rst_ni,
                out_valid_o && (status_o != STATUS_OK) && (read_data_o != '0),
                "data returned with an error status")

  // No result is offered straight out of reset.
  `ASSERT_PROP(a_reset_quiet, clk_i, rst_ni,
               $rose(rst_ni) |-> !out_valid_o,
               "result offered at reset release")

  // A compute transfer holds off the input while the product is formed.
  `ASSERT_PROP(a_compute_stall, clk_i, rst_ni,
               in_valid_i && !in_stall_o && (func_i == FUNC_COMPUTE) |=> in_stall_o,
               "input taken while a compute runs")

endmodule

bind gf2_polynomial_multiplier gfm_checker u_gfm_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GF(2) polynomial multiplier: queued commands, a checking
// monitor and a bit-accurate predictor of the operand and product stores.
// Depends on gfm_pkg and gf2_polynomial_multiplier.

module tb_top;
  import gfm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    func_e              op;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
  } command_t;

  typedef struct {
    logic [WORD_W-1:0] data;
    status_e           st;
  } outcome_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         func      = FUNC_NONE;
  logic [INDEX_W-1:0] index     = '0;
  logic [WORD_W-1:0]  a_word    = '0;
  logic [WORD_W-1:0]  b_word    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [WORD_W-1:0]  read_data;
  logic [1:0]         status;

  // Predictor state: operand words, product words and the product-valid mark.
  logic [WORD_W-1:0] first_words [OPERAND_WORDS];
  logic [WORD_W-1:0] second_words[OPERAND_WORDS];
  logic [WORD_W-1:0] product_words[PRODUCT_WORDS];
  bit                product_ready = 1'b0;

  command_t pending_commands[$];
  outcome_t awaited_outcomes[$];

  int  queued_count   = 0;
  int  accepted_count = 0;
  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_requests  = 0;
  int  holds_served   = 0;
  int  hold_left      = 0;
  bit  in_xfer        = 1'b0;
  bit  out_xfer       = 1'b0;

  gf2_polynomial_multiplier uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .func_i     (func),
    .index_i    (index),
    .a_word_i   (a_word),
    .b_word_i   (b_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .read_data_o(read_data),
    .status_o   (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Carry-less product of two 64-bit words, 127 significant bits.
  function automatic logic [127:0] carryless_mul64(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] acc;
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      if (y[k]) begin
        acc = acc ^ ({64'b0, x} << k);
      end
    end
    return acc;
  endfunction

  // Full double-length product of the two stored operands.
  function automatic void multiply_operands();
    logic [127:0] part;
    for (int w = 0; w < PRODUCT_WORDS; w++) begin
      product_words[w] = '0;
    end
    for (int i = 0; i < OPERAND_WORDS; i++) begin
      for (int j = 0; j < OPERAND_WORDS; j++) begin
        part = carryless_mul64(first_words[i], second_words[j]);
        product_words[i + j]     = product_words[i + j] ^ part[63:0];
        product_words[i + j + 1] = product_words[i + j + 1] ^ part[127:64];
      end
    end
    product_ready = 1'b1;
  endfunction

  // Applies one command to the predictor state and returns the result it yields.
  function automatic outcome_t gf2_command_outcome(input command_t c);
    outcome_t r;
    r.data = '0;
    r.st   = STATUS_OK;
    case (c.op)
      FUNC_LOAD: begin
        if (c.idx < OPERAND_WORDS) begin
          first_words[c.idx]  = c.a;
          second_words[c.idx] = c.b;
          product_ready       = 1'b0;
        end else begin
          r.st = STATUS_RANGE;
        end
      end
      FUNC_COMPUTE: begin
        multiply_operands();
      end
      FUNC_READ: begin
        if (c.idx >= PRODUCT_WORDS) begin
          r.st = STATUS_RANGE;
        end else if (!product_ready) begin
          r.st = STATUS_NOT_READY;
        end else begin
          r.data = product_words[c.idx];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Operand words: mostly dense random, with zero, all-ones and single-bit words mixed in.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_command(input func_e op, input int idx,
                              input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    command_t c;
    c.op  = op;
    c.idx = INDEX_W'(idx);
    c.a   = a;
    c.b   = b;
    pending_commands.push_back(c);
    queued_count++;
  endtask

  // Occasional out-of-range load, ignored command or read at a random index between the well-formed ones.
  task automatic maybe_noise();
    case ($urandom_range(19))
      0: push_command(FUNC_LOAD, $urandom_range(OPERAND_WORDS, 255), random_word(), random_word());
      1: push_command(FUNC_NONE, $urandom_range(255), random_word(), random_word());
      2: push_command(FUNC_READ, $urandom_range(255), random_word(), random_word());
      default: begin
      end
    endcase
  endtask

  // Reload some operand words, multiply when do_compute is set, then read the product back.
  task automatic queue_session(input int reloads, input int reads, input bit do_compute);
    for (int n = 0; n < reloads; n++) begin
      maybe_noise();
      push_command(FUNC_LOAD, $urandom_range(OPERAND_WORDS - 1), random_word(), random_word());
    end
    if (do_compute) begin
      push_command(FUNC_COMPUTE, $urandom_range(255), random_word(), random_word());
    end
    for (int n = 0; n < reads; n++) begin
      maybe_noise();
      if ($urandom_range(39) == 0) begin
        // A stray load in the middle of the reads drops the product again.
        push_command(FUNC_LOAD, $urandom_range(OPERAND_WORDS - 1), random_word(), random_word());
      end
      if ($urandom_range(15) == 0) begin
        push_command(FUNC_READ, $urandom_range(PRODUCT_WORDS, 255), random_word(), random_word());
      end else begin
        push_command(FUNC_READ, $urandom_range(PRODUCT_WORDS - 1), random_word(), random_word());
      end
    end
  endtask

  // Waits until every queued command has been transferred and answered.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (accepted_count != queued_count || awaited_outcomes.size() != 0);
  endtask

  // Sender: offers the next queued command at the falling edge once the previous one is taken.
  always @(negedge clk) begin : drive_commands
    command_t cmd;
    if (rst_n && (!in_valid || in_xfer)) begin
      if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = pending_commands.pop_front();
        in_valid <= 1'b1;
        func     <= cmd.op;
        index    <= cmd.idx;
        a_word   <= cmd.a;
        b_word   <= cmd.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer in order.
  always @(posedge clk) begin : check_results
    command_t seen;
    outcome_t want;
    if (rst_n) begin
      in_xfer  = in_valid && !in_stall;
      out_xfer = out_valid && !out_stall;
      if (in_xfer) begin
        seen.op  = func_e'(func);
        seen.idx = index;
        seen.a   = a_word;
        seen.b   = b_word;
        awaited_outcomes.push_back(gf2_command_outcome(seen));
        accepted_count++;
      end
      if (out_xfer) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result, read_data %h status %0d", $time, read_data, status);
          mismatch_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (read_data !== want.data) begin
            $display("%0t: read_data mismatch, expected %h, got %h",
                     $time, want.data, read_data);
            mismatch_count++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.st, status);
            mismatch_count++;
          end
        end
      end
      // The watchdog counts cycles without any transfer on either channel.
      if (in_xfer || out_xfer) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus: directed checks first, then random sessions under changing idle patterns.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reads before any product exists, out-of-range accesses and the unused selector.
    push_command(FUNC_READ, 0, '0, '0);
    push_command(FUNC_READ, PRODUCT_WORDS - 1, '1, '1);
    push_command(FUNC_READ, PRODUCT_WORDS, '0, '0);
    push_command(FUNC_READ, 8'hFF, '1, '1);
    push_command(FUNC_NONE, 8'hAA, '1, '1);
    push_command(FUNC_LOAD, OPERAND_WORDS, '1, '1);
    push_command(FUNC_LOAD, 8'hFF, '1, '1);

    // Every operand word must be written before the first multiply.
    for (int w = 0; w < OPERAND_WORDS; w++) begin
      if (w == 0) begin
        push_command(FUNC_LOAD, w, '1, '1);
      end else if (w == OPERAND_WORDS - 1) begin
        push_command(FUNC_LOAD, w, 64'd1 << 63, 64'd1 << 63);
      end else if (w == OPERAND_WORDS / 2) begin
        push_command(FUNC_LOAD, w, '0, random_word());
      end else begin
        push_command(FUNC_LOAD, w, random_word(), random_word());
      end
    end
    push_command(FUNC_READ, 0, '0, '0);
    push_command(FUNC_COMPUTE, 8'hFF, '1, '1);
    push_command(FUNC_READ, 0, '0, '0);
    push_command(FUNC_READ, 1, '0, '0);
    push_command(FUNC_READ, OPERAND_WORDS - 1, '0, '0);
    push_command(FUNC_READ, OPERAND_WORDS, '0, '0);
    push_command(FUNC_READ, PRODUCT_WORDS - 2, '0, '0);
    push_command(FUNC_READ, PRODUCT_WORDS - 1, '0, '0);
    push_command(FUNC_READ, PRODUCT_WORDS, '0, '0);
    push_command(FUNC_NONE, 0, '0, '0);
    push_command(FUNC_READ, 0, '0, '0);
    // A load drops the product until the next multiply.
    push_command(FUNC_LOAD, 5, random_word(), random_word());
    push_command(FUNC_READ, 0, '0, '0);
    push_command(FUNC_COMPUTE, 0, '0, '0);
    push_command(FUNC_READ, 5, '0, '0);
    push_command(FUNC_READ, PRODUCT_WORDS - 1, '0, '0);
    wait_drained();

    for (int rep = 0; rep < 3; rep++) begin
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
          default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
        queue_session($urandom_range(5, 30), $urandom_range(70, 110), $urandom_range(7) != 0);
        wait_drained();
      end
      if (rep == 1) begin
        // The receiver holds off while the sender keeps offering, so the block fills up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (int n = 0; n < 60; n++) begin
          push_command(FUNC_READ, $urandom_range(255), random_word(), random_word());
        end
        wait_drained();
      end
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
